/* hdl/assert_macros.svh */
// Assertion macros used by the top level RTL file of the fractional delay allpass block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General clocked property, disabled while reset is high
`define ASSERT_SYNC(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// Clocked implication: when the antecedent holds, the consequent holds too
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

/* hdl/fdap_pkg.sv */
// Package: constants, types and helpers of the fractional delay allpass block.
`timescale 1ns / 1ps
`default_nettype none

package fdap_pkg;

   // Delay line geometry
   localparam int LINE_DEPTH = 4096;
   localparam int IDX_W      = $clog2(LINE_DEPTH);

   // Field widths
   localparam int SAMPLE_W  = 16;
   localparam int GAIN_W    = 16;
   localparam int DELAY_W   = 21;
   localparam int FRAC_W    = 8;
   localparam int GAIN_FRAC = 15;

   // Read position arithmetic: span is the line length in fractional samples
   localparam int SPAN   = LINE_DEPTH * (2 ** FRAC_W);
   localparam int SPAN_W = $clog2(SPAN + 1);
   localparam int CALC_W = ((SPAN_W > DELAY_W) ? SPAN_W : DELAY_W) + 1;
   localparam int POS_W  = IDX_W + FRAC_W;

   // Interpolation and gain products
   localparam int INTERP_W     = SAMPLE_W + FRAC_W + 2;
   localparam int INTERP_ROUND = 2 ** (FRAC_W - 1);
   localparam int PROD_W       = GAIN_W + SAMPLE_W;
   localparam int GAIN_ROUND   = 2 ** (GAIN_FRAC - 1);
   localparam int SUM_W        = SAMPLE_W + 2;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_LOOP_GAIN    = 1'b0;
   localparam logic REG_DELAY_LENGTH = 1'b1;
   localparam logic [GAIN_W-1:0]  LOOP_GAIN_RESET    = GAIN_W'(3277);
   localparam logic [DELAY_W-1:0] DELAY_LENGTH_RESET = DELAY_W'(256);

   // Controller to datapath commands
   typedef struct packed {
      logic clear;
      logic accept;
      logic interp;
      logic gain;
      logic store;
      logic load_out;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic clear_last;
   } status_type;

   // Saturate a widened sum to the sample range
   function automatic logic signed [SAMPLE_W-1:0] sat_sample(
      input logic signed [SUM_W-1:0] v);
      logic ovf;
      ovf = (v[SUM_W-1:SAMPLE_W-1] != {(SUM_W-SAMPLE_W+1){1'b0}}) &&
            (v[SUM_W-1:SAMPLE_W-1] != {(SUM_W-SAMPLE_W+1){1'b1}});
      if (ovf) begin
         sat_sample = {v[SUM_W-1], {(SAMPLE_W-1){~v[SUM_W-1]}}};
      end else begin
         sat_sample = v[SAMPLE_W-1:0];
      end
   endfunction

endpackage

`default_nettype wire

/* hdl/fdap_ram.sv */
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module fdap_ram #(
   parameter int  WIDTH  = 16,
   parameter int  DEPTH  = 4096,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [WIDTH-1:0]  wdata,
   input  wire logic [ADDR_W-1:0] raddr_a,
   input  wire logic [ADDR_W-1:0] raddr_b,
   output logic      [WIDTH-1:0]  rdata_a,
   output logic      [WIDTH-1:0]  rdata_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_a_ff;
   logic [WIDTH-1:0] rdata_b_ff;

   // Write and registered reads; a read at the written address sees old data
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_a_ff <= mem_ff[raddr_a];
      rdata_b_ff <= mem_ff[raddr_b];
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

`default_nettype wire

/* hdl/fdap_csr.sv */
// Configuration registers behind the APB-style port.
`timescale 1ns / 1ps
`default_nettype none

module fdap_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [fdap_pkg::CSR_ADDR_W-1:0]      paddr,
   input  wire logic [fdap_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic      [fdap_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                      pready,
   output logic signed [fdap_pkg::GAIN_W-1:0]        loop_gain,
   output logic      [fdap_pkg::DELAY_W-1:0]         delay_length
);

   logic [fdap_pkg::GAIN_W-1:0]  loop_gain_ff;
   logic [fdap_pkg::DELAY_W-1:0] delay_length_ff;
   logic                         wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite & pready;

   // Register writes; the byte offset bits are not decoded
   always_ff @(posedge clock) begin
      if (reset) begin
         loop_gain_ff    <= fdap_pkg::LOOP_GAIN_RESET;
         delay_length_ff <= fdap_pkg::DELAY_LENGTH_RESET;
      end else if (wr_en) begin
         case (paddr[2])
            fdap_pkg::REG_LOOP_GAIN: begin
               loop_gain_ff <= pwdata[fdap_pkg::GAIN_W-1:0];
            end
            fdap_pkg::REG_DELAY_LENGTH: begin
               delay_length_ff <= pwdata[fdap_pkg::DELAY_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Read back: gain sign-extended, delay zero-extended
   always_comb begin
      case (paddr[2])
         fdap_pkg::REG_LOOP_GAIN: begin
            prdata = {{(fdap_pkg::CSR_DATA_W-fdap_pkg::GAIN_W){loop_gain_ff[fdap_pkg::GAIN_W-1]}},
                      loop_gain_ff};
         end
         fdap_pkg::REG_DELAY_LENGTH: begin
            prdata = {{(fdap_pkg::CSR_DATA_W-fdap_pkg::DELAY_W){1'b0}}, delay_length_ff};
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   assign loop_gain    = $signed(loop_gain_ff);
   assign delay_length = delay_length_ff;

endmodule

`default_nettype wire

/* hdl/fdap_ctrl.sv */
// Controller: sequences the clearing pass and each sample through the datapath.
`timescale 1ns / 1ps
`default_nettype none

module fdap_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire fdap_pkg::status_type status,
   output fdap_pkg::cmd_type         cmd
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_INTERP,
      S_GAIN,
      S_STORE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_READ;
            end
         end
         S_READ: begin
            state_in = S_INTERP;
         end
         S_INTERP: begin
            cmd.interp = 1'b1;
            state_in   = S_GAIN;
         end
         S_GAIN: begin
            cmd.gain = 1'b1;
            state_in = S_STORE;
         end
         S_STORE: begin
            // hold here until the output register can take the result
            cmd.store = 1'b1;
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register valid flag
   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

/* hdl/fdap_datapath.sv */
// Datapath: read position, interpolation, shared gain multiplier, delay line access.
`timescale 1ns / 1ps
`default_nettype none

module fdap_datapath (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire fdap_pkg::cmd_type                     cmd,
   output fdap_pkg::status_type                       status,
   input  wire logic signed [fdap_pkg::GAIN_W-1:0]    loop_gain,
   input  wire logic [fdap_pkg::DELAY_W-1:0]          delay_length,
   input  wire logic signed [fdap_pkg::SAMPLE_W-1:0]  sample_in,
   output logic signed [fdap_pkg::SAMPLE_W-1:0]       sample_out,
   output logic                                       ram_we,
   output logic [fdap_pkg::IDX_W-1:0]                 ram_waddr,
   output logic [fdap_pkg::SAMPLE_W-1:0]              ram_wdata,
   output logic [fdap_pkg::IDX_W-1:0]                 ram_raddr_a,
   output logic [fdap_pkg::IDX_W-1:0]                 ram_raddr_b,
   input  wire logic [fdap_pkg::SAMPLE_W-1:0]         ram_rdata_a,
   input  wire logic [fdap_pkg::SAMPLE_W-1:0]         ram_rdata_b
);

   localparam int IW = fdap_pkg::IDX_W;
   localparam int SW = fdap_pkg::SAMPLE_W;
   localparam int CW = fdap_pkg::CALC_W;
   localparam int PW = fdap_pkg::POS_W;
   localparam int FW = fdap_pkg::FRAC_W;
   localparam int NW = fdap_pkg::INTERP_W;
   localparam int MW = fdap_pkg::PROD_W;
   localparam int UW = fdap_pkg::SUM_W;
   localparam logic [IW-1:0] LAST_IDX = IW'(fdap_pkg::LINE_DEPTH - 1);

   // Control state
   logic [IW-1:0] wr_ff;
   logic [IW-1:0] wr_in;
   logic [IW-1:0] clear_cnt_ff;

   // Payload registers
   logic signed [SW-1:0] x_ff;
   logic [IW-1:0]        i1_ff;
   logic [IW-1:0]        i2_ff;
   logic [FW-1:0]        frac_ff;
   logic signed [SW-1:0] d_ff;
   logic signed [SW-1:0] v_ff;
   logic signed [SW-1:0] out_ff;

   // Read position
   logic [CW-1:0] dly_ext;
   logic [CW-1:0] span_ext;
   logic [CW-1:0] dly_cl;
   logic [CW-1:0] wpos;
   logic [CW-1:0] pos_full;
   logic [PW-1:0] pos;
   logic [IW-1:0] i1_in;
   logic [IW-1:0] i2_in;

   // Interpolation
   logic signed [NW-1:0] cur_ext;
   logic signed [NW-1:0] diff;
   logic signed [NW-1:0] frac_ext;
   logic signed [NW-1:0] interp_prod;
   logic signed [NW-1:0] interp_sum;
   logic signed [SW-1:0] d_in;

   // Shared gain multiplier
   logic signed [SW-1:0] mul_b;
   logic signed [MW-1:0] gain_prod;
   logic signed [MW-1:0] gain_rnd;
   logic signed [UW-1:0] gain_q;
   logic signed [UW-1:0] acc_a;
   logic signed [UW-1:0] acc_sum;
   logic signed [SW-1:0] acc_sat;

   // Delay clamped to the line length, kept up to date every cycle
   assign dly_ext  = CW'(delay_length);
   assign span_ext = CW'(fdap_pkg::SPAN);
   assign dly_cl   = (dly_ext > span_ext) ? span_ext : dly_ext;

   // Write index advances before use
   assign wr_in = (wr_ff == LAST_IDX) ? '0 : wr_ff + IW'(1);

   // Read position = advanced write index minus delay, wrapped into the line
   assign wpos     = CW'({wr_in, {FW{1'b0}}});
   assign pos_full = (wpos < dly_cl) ? (wpos - dly_cl + span_ext) : (wpos - dly_cl);
   assign pos      = pos_full[PW-1:0];
   assign i1_in    = pos[PW-1:FW];
   assign i2_in    = (i1_in == LAST_IDX) ? '0 : i1_in + IW'(1);

   // d = round(cur + (next - cur) * frac / 256)
   assign cur_ext     = NW'($signed(ram_rdata_a));
   assign diff        = NW'($signed(ram_rdata_b)) - cur_ext;
   assign frac_ext    = NW'($signed({1'b0, frac_ff}));
   assign interp_prod = diff * frac_ext;
   assign interp_sum  = (cur_ext <<< FW) + interp_prod + NW'(fdap_pkg::INTERP_ROUND);
   assign d_in        = interp_sum[SW+FW-1:FW];

   // Gain step: stored value in the gain state, output in the store state
   assign mul_b     = cmd.store ? v_ff : d_ff;
   assign gain_prod = MW'(loop_gain) * MW'(mul_b);
   assign gain_rnd  = gain_prod + MW'(fdap_pkg::GAIN_ROUND);
   assign gain_q    = UW'($signed(gain_rnd[MW-1:fdap_pkg::GAIN_FRAC]));
   assign acc_a     = cmd.store ? UW'(d_ff) : UW'(x_ff);
   assign acc_sum   = cmd.store ? (acc_a - gain_q) : (acc_a + gain_q);
   assign acc_sat   = fdap_pkg::sat_sample(acc_sum);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff        <= '0;
         clear_cnt_ff <= '0;
      end else begin
         if (cmd.accept) begin
            wr_ff <= wr_in;
         end
         if (cmd.clear) begin
            clear_cnt_ff <= (clear_cnt_ff == LAST_IDX) ? '0 : clear_cnt_ff + IW'(1);
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         x_ff    <= sample_in;
         i1_ff   <= i1_in;
         i2_ff   <= i2_in;
         frac_ff <= pos[FW-1:0];
      end
      if (cmd.interp) begin
         d_ff <= d_in;
      end
      if (cmd.gain) begin
         v_ff <= acc_sat;
      end
      if (cmd.load_out) begin
         out_ff <= acc_sat;
      end
   end

   // Delay line access: zero fill during the clearing pass, else the stored value
   assign ram_we      = cmd.clear | cmd.store;
   assign ram_waddr   = cmd.clear ? clear_cnt_ff : wr_ff;
   assign ram_wdata   = cmd.clear ? '0 : v_ff;
   assign ram_raddr_a = i1_ff;
   assign ram_raddr_b = i2_ff;

   assign status.clear_last = (clear_cnt_ff == LAST_IDX);
   assign sample_out        = out_ff;

endmodule

`default_nettype wire

/* hdl/fractional_delay_allpass_core.sv */
// Top level of the fractional delay allpass: controller, datapath, delay line RAM, registers.
//
//   Channel   Direction  Handshake           Payload
//   req       in         req_valid/ready     req_sample_in   (signed 16)
//   rsp       out        rsp_valid/ready     rsp_sample_out  (signed 16)
//   csr       in/out     psel/penable/pready loop_gain @ 0x0, delay_length @ 0x4
//
// Each accepted sample passes through a registered dual read of the delay line, then
// interpolation, then the gain and store steps on the one shared gain multiplier, before its
// result reaches the output register. A new sample is taken only after the last leaves the store step.
// After reset a clearing pass zeroes the delay line, one entry a cycle, with req_ready
// low; register writes are taken meanwhile.
// A stalled output holds the finished sample in the store step until the register frees.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module fractional_delay_allpass_core (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic signed [fdap_pkg::SAMPLE_W-1:0]  req_sample_in,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic signed [fdap_pkg::SAMPLE_W-1:0]       rsp_sample_out,
   input  wire logic                                  psel,
   input  wire logic                                  penable,
   input  wire logic                                  pwrite,
   input  wire logic [fdap_pkg::CSR_ADDR_W-1:0]       paddr,
   input  wire logic [fdap_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [fdap_pkg::CSR_DATA_W-1:0]            prdata,
   output logic                                       pready
);

   fdap_pkg::cmd_type    cmd;
   fdap_pkg::status_type status;

   logic signed [fdap_pkg::GAIN_W-1:0] loop_gain;
   logic [fdap_pkg::DELAY_W-1:0]       delay_length;

   logic                              ram_we;
   logic [fdap_pkg::IDX_W-1:0]        ram_waddr;
   logic [fdap_pkg::SAMPLE_W-1:0]     ram_wdata;
   logic [fdap_pkg::IDX_W-1:0]        ram_raddr_a;
   logic [fdap_pkg::IDX_W-1:0]        ram_raddr_b;
   logic [fdap_pkg::SAMPLE_W-1:0]     ram_rdata_a;
   logic [fdap_pkg::SAMPLE_W-1:0]     ram_rdata_b;

   // Configuration registers
   fdap_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .loop_gain    (loop_gain),
      .delay_length (delay_length)
   );

   // Sequencer
   fdap_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Arithmetic and delay line addressing
   fdap_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .loop_gain    (loop_gain),
      .delay_length (delay_length),
      .sample_in    (req_sample_in),
      .sample_out   (rsp_sample_out),
      .ram_we       (ram_we),
      .ram_waddr    (ram_waddr),
      .ram_wdata    (ram_wdata),
      .ram_raddr_a  (ram_raddr_a),
      .ram_raddr_b  (ram_raddr_b),
      .ram_rdata_a  (ram_rdata_a),
      .ram_rdata_b  (ram_rdata_b)
   );

   // Delay line
   fdap_ram #(
      .WIDTH (fdap_pkg::SAMPLE_W),
      .DEPTH (fdap_pkg::LINE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .we      (ram_we),
      .waddr   (ram_waddr),
      .wdata   (ram_wdata),
      .raddr_a (ram_raddr_a),
      .raddr_b (ram_raddr_b),
      .rdata_a (ram_rdata_a),
      .rdata_b (ram_rdata_b)
   );

   // Checks on the sequencing
   `ASSERT_IMPL(a_no_accept_in_clear, clock, reset, cmd.clear, !req_ready, "transaction accepted during clearing pass")
   `ASSERT_IMPL(a_no_accept_on_write, clock, reset, ram_we, !req_ready, "transaction accepted while delay line written")
   `ASSERT_SYNC(a_store_after_accept, clock, reset, cmd.accept |-> ##4 cmd.store, "store step not four cycles after acceptance")
   `ASSERT_SYNC(a_valid_from_store, clock, reset, $rose(rsp_valid) |-> $past(cmd.store), "result offered without a store step")

endmodule

`default_nettype wire

/* tb/allpass_output_checker.sv */
// Checker: watches the sample channels and register writes, predicts and compares outputs.
`timescale 1ns / 1ps

module allpass_output_checker (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   input  logic                                    req_ready,
   input  logic signed [fdap_pkg::SAMPLE_W-1:0]    req_sample_in,
   input  logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   input  logic signed [fdap_pkg::SAMPLE_W-1:0]    rsp_sample_out,
   input  logic                                    psel,
   input  logic                                    penable,
   input  logic                                    pwrite,
   input  logic [fdap_pkg::CSR_ADDR_W-1:0]         paddr,
   input  logic [fdap_pkg::CSR_DATA_W-1:0]         pwdata,
   input  logic                                    pready,
   output int                                      mismatch_count,
   output int                                      samples_in_flight
);
   import fdap_pkg::*;

   localparam int MAX_REPORTS = 30;

   // Own copy of the delay line, write index and registers
   logic signed [SAMPLE_W-1:0] echo_line [0:LINE_DEPTH-1];
   int                         head_index;
   logic signed [GAIN_W-1:0]   gain_q15;
   logic [DELAY_W-1:0]         delay_fx;

   // Outputs predicted but not yet seen, oldest first
   logic signed [SAMPLE_W-1:0] expected_samples [$];

   initial begin
      mismatch_count    = 0;
      samples_in_flight = 0;
   end

   // One line per mismatch, printing capped, counting not
   task automatic report_mismatch(input string what);
      if (mismatch_count < MAX_REPORTS) begin
         $display("[%0t] mismatch: %s", $realtime, what);
      end
      mismatch_count++;
   endtask

   function automatic logic signed [SAMPLE_W-1:0] clamp_sample(input longint v);
      if (v > 32767) begin
         return 16'sh7FFF;
      end
      if (v < -32768) begin
         return 16'sh8000;
      end
      return v[SAMPLE_W-1:0];
   endfunction

   // Q1.15 gain times an integer, rounded half up (arithmetic shift floors)
   function automatic longint scale_by_gain(input logic signed [GAIN_W-1:0] g,
                                            input longint x);
      return (longint'(g) * x + 16384) >>> GAIN_FRAC;
   endfunction

   // Advance the line by one sample and queue the filter output
   task automatic predict_allpass(input logic signed [SAMPLE_W-1:0] x);
      longint span;
      longint dly;
      longint pos;
      longint mix;
      longint tap;
      longint fed;
      int     lo_idx;
      int     hi_idx;
      int     frac;
      span = longint'(LINE_DEPTH) * 256;
      dly  = longint'(delay_fx);
      if (dly > span) begin
         dly = span;
      end
      head_index = (head_index + 1) % LINE_DEPTH;
      pos = longint'(head_index) * 256 - dly;
      if (pos < 0) begin
         pos += span;
      end
      lo_idx = int'(pos >> FRAC_W) % LINE_DEPTH;
      frac   = int'(pos & 255);
      hi_idx = (lo_idx + 1) % LINE_DEPTH;
      // linear interpolation between neighbouring taps
      mix = longint'(echo_line[hi_idx]) * frac +
            longint'(echo_line[lo_idx]) * (256 - frac);
      tap = (mix + 128) >>> FRAC_W;
      fed = clamp_sample(longint'(x) + scale_by_gain(gain_q15, tap));
      echo_line[head_index] = fed[SAMPLE_W-1:0];
      expected_samples.push_back(clamp_sample(tap - scale_by_gain(gain_q15, fed)));
   endtask

   always @(posedge clock) begin
      logic signed [SAMPLE_W-1:0] want;
      if (reset) begin
         for (int i = 0; i < LINE_DEPTH; i++) begin
            echo_line[i] = '0;
         end
         head_index = 0;
         gain_q15   = LOOP_GAIN_RESET;
         delay_fx   = DELAY_LENGTH_RESET;
         expected_samples.delete();
      end else begin
         // register write transaction
         if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
            case (paddr[CSR_ADDR_W-1:2])
               REG_LOOP_GAIN: begin
                  gain_q15 = pwdata[GAIN_W-1:0];
               end
               REG_DELAY_LENGTH: begin
                  delay_fx = pwdata[DELAY_W-1:0];
               end
               default: begin
               end
            endcase
         end
         // input transaction
         if (req_valid && req_ready) begin
            predict_allpass(req_sample_in);
         end
         // output transaction
         if (rsp_valid && rsp_ready) begin
            if (expected_samples.size() == 0) begin
               report_mismatch($sformatf("output %0d with nothing expected",
                                         rsp_sample_out));
            end else begin
               want = expected_samples.pop_front();
               if (rsp_sample_out !== want) begin
                  report_mismatch($sformatf("sample_out got %0d, expected %0d",
                                            rsp_sample_out, want));
               end
            end
         end
      end
      samples_in_flight <= expected_samples.size();
   end

endmodule

/* tb/tb_fractional_delay_allpass_core.sv */
// Testbench top: clock, reset, register settings and sample stimulus, final verdict.
`timescale 1ns / 1ps

module tb_fractional_delay_allpass_core;
   import fdap_pkg::*;

   localparam int RANDOM_PHASES    = 10;
   localparam int ITEMS_PER_PHASE  = 95;
   localparam int SETTLE_CYCLES    = 10;

   logic                         clock          = 1'b0;
   logic                         reset          = 1'b1;
   logic                         req_valid      = 1'b0;
   logic                         req_ready;
   logic signed [SAMPLE_W-1:0]   req_sample_in  = '0;
   logic                         rsp_valid;
   logic                         rsp_ready      = 1'b0;
   logic signed [SAMPLE_W-1:0]   rsp_sample_out;
   logic                         psel           = 1'b0;
   logic                         penable        = 1'b0;
   logic                         pwrite         = 1'b0;
   logic [CSR_ADDR_W-1:0]        paddr          = '0;
   logic [CSR_DATA_W-1:0]        pwdata         = '0;
   logic [CSR_DATA_W-1:0]        prdata;
   logic                         pready;

   int   mismatch_count;
   int   samples_in_flight;
   logic quiet_phase = 1'b0;

   fractional_delay_allpass_core uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   allpass_output_checker output_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sample_in     (req_sample_in),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_sample_out    (rsp_sample_out),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .pready            (pready),
      .mismatch_count    (mismatch_count),
      .samples_in_flight (samples_in_flight)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Gap length: mostly none or short, now and then long
   function automatic int idle_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (quiet_phase || r < 50) begin
         return 0;
      end
      if (r < 85) begin
         return $urandom_range(1, 3);
      end
      if (r < 97) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         default: return SAMPLE_W'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [GAIN_W-1:0] pick_gain();
      case ($urandom_range(0, 5))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return '0;
         3:       return LOOP_GAIN_RESET;
         default: return GAIN_W'($urandom_range(0, 65535));
      endcase
   endfunction

   // Delays: zero, sub-sample, short, full depth, beyond depth, anywhere
   function automatic logic [DELAY_W-1:0] pick_delay();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return DELAY_W'($urandom_range(1, 255));
         2:       return DELAY_LENGTH_RESET;
         3:       return DELAY_W'($urandom_range(257, 16 * 256));
         4:       return DELAY_W'(SPAN);
         5:       return DELAY_W'($urandom_range(SPAN + 1, 2 ** DELAY_W - 1));
         6:       return DELAY_W'($urandom_range(0, SPAN));
         default: return DELAY_W'($urandom_range(256, 64 * 256));
      endcase
   endfunction

   // Register write transaction: setup then access, unused data bits random
   task automatic write_reg(input logic reg_sel, input logic [CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'({reg_sel, 2'b00});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do begin
         @(negedge clock);
      end while (!pready);
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_gain(input logic [GAIN_W-1:0] g);
      write_reg(REG_LOOP_GAIN, {16'($urandom_range(0, 65535)), g});
   endtask

   task automatic set_delay(input logic [DELAY_W-1:0] dly);
      write_reg(REG_DELAY_LENGTH, {11'($urandom_range(0, 2047)), dly});
   endtask

   // Input transaction; returns at the edge that accepted it, valid left high
   task automatic push_sample(input logic signed [SAMPLE_W-1:0] x);
      int gap;
      gap = idle_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_in <= x;
      do begin
         @(negedge clock);
      end while (!req_ready);
      @(posedge clock);
   endtask

   // Drop valid after the last sample and wait for every output
   task automatic drain_outputs();
      req_valid <= 1'b0;
      @(posedge clock);
      while (samples_in_flight != 0) begin
         @(posedge clock);
      end
   endtask

   // Output side: ready bursts broken by random stalls
   initial begin
      int burst;
      int gap;
      @(posedge clock);
      forever begin
         rsp_ready <= 1'b1;
         burst = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
         repeat (burst) @(posedge clock);
         gap = idle_cycles();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   // Main sequence
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // max gain, delay of one and a half samples; drives the stored value into saturation
      set_gain(16'h7FFF);
      set_delay(DELAY_W'(384));
      push_sample(16'sh7FFF);
      push_sample(16'sh7FFF);
      push_sample(16'sh7FFF);
      push_sample(16'sh8000);
      push_sample(16'sh8000);
      push_sample(16'sh8000);
      push_sample(16'sh0000);
      push_sample(16'sh0001);
      push_sample(-16'sd1);
      push_sample(16'sh7FFF);
      drain_outputs();

      // most negative gain, zero delay reads the entry about to be overwritten
      set_gain(16'h8000);
      set_delay('0);
      push_sample(16'sh7FFF);
      push_sample(16'sh8000);
      push_sample(16'sh8000);
      push_sample(16'sh7FFF);
      push_sample(16'sh0001);
      push_sample(-16'sd1);
      drain_outputs();

      // zero gain, delay beyond the line acts as the full depth
      set_gain('0);
      set_delay({DELAY_W{1'b1}});
      push_sample(16'sh8000);
      push_sample(16'sh7FFF);
      push_sample(16'sh0000);
      drain_outputs();

      // reset gain, exactly full depth
      set_gain(LOOP_GAIN_RESET);
      set_delay(DELAY_W'(SPAN));
      push_sample(-16'sd1);
      push_sample(16'sh7FFF);
      push_sample(16'sh8000);
      push_sample(16'sh0000);
      push_sample(16'sh4000);
      drain_outputs();

      // random settings and samples
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         quiet_phase = (p % 4 == 3);
         set_gain(pick_gain());
         set_delay(pick_delay());
         repeat (ITEMS_PER_PHASE) push_sample(pick_sample());
         drain_outputs();
      end
      quiet_phase = 1'b0;

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && samples_in_flight == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

/* sim.f */
+incdir+hdl
hdl/fdap_pkg.sv
hdl/fdap_ram.sv
hdl/fdap_csr.sv
hdl/fdap_ctrl.sv
hdl/fdap_datapath.sv
hdl/fractional_delay_allpass_core.sv
tb/allpass_output_checker.sv
tb/tb_fractional_delay_allpass_core.sv
